// ===== src/thermal_softening_power_law_core_assert.svh =====
// Assertion macros used by the checker file of the softening core.
// No dependencies; take in with `include.
`ifndef THERMAL_SOFTENING_POWER_LAW_CORE_ASSERT_SVH
`define THERMAL_SOFTENING_POWER_LAW_CORE_ASSERT_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsp assertion failed");

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsp assertion failed");

`endif

// ===== src/tsp_pkg.sv =====
// Package for the thermal softening core: widths, register indexes and the
// log2 / exp2 interpolation tables built at elaboration. No dependencies.
`default_nettype none

package tsp_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int TAB_W       = 34;
   localparam int KW          = $clog2(TABLE_DEPTH + 1);
   localparam int PW          = 32 + KW;

   localparam logic [1:0] CSR_REF_TEMP = 2'd0;
   localparam logic [1:0] CSR_SPAN     = 2'd1;
   localparam logic [1:0] CSR_EXPONENT = 2'd2;

   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

   typedef logic [TAB_W-1:0] tab_type [TABLE_DEPTH+1];

   typedef struct packed {
      logic               live;
      logic [15:0]        expo;
      logic signed [16:0] am1;
   } side_type;

   // log2(1 + i/N) by repeated squaring on a Q.31 value
   function automatic tab_type build_log();
      tab_type     tab;
      logic [63:0] x;
      logic [31:0] y;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         if (i < TABLE_DEPTH) begin
            x = ((64'(TABLE_DEPTH) + 64'(i)) << 31) / 64'(TABLE_DEPTH);
            y = '0;
            for (int b = 0; b < 32; b++) begin
               x = (x * x) >> 31;
               y = y << 1;
               if (x >= ONE_Q32) begin
                  x    = x >> 1;
                  y[0] = 1'b1;
               end
            end
            tab[i] = TAB_W'(y);
         end else begin
            tab[i] = TAB_W'(ONE_Q32);
         end
      end
      return tab;
   endfunction

   // 2^(i/N) by a truncated Taylor series of e^z
   function automatic tab_type build_exp();
      tab_type     tab;
      logic [63:0] yf;
      logic [63:0] z;
      logic [63:0] term;
      logic [63:0] sum;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         yf   = (64'(i) << 32) / 64'(TABLE_DEPTH);
         z    = (yf * LN2_Q32) >> 32;
         term = ONE_Q32;
         sum  = ONE_Q32;
         for (int k = 1; k <= 16; k++) begin
            term = ((term * z) >> 32) / 64'(k);
            sum  = sum + term;
         end
         tab[i] = TAB_W'(sum);
      end
      return tab;
   endfunction

   localparam tab_type LOG_TAB = build_log();
   localparam tab_type EXP_TAB = build_exp();

endpackage

`default_nettype wire

// ===== src/thermal_softening_power_law_core.sv =====
// Power-law thermal softening core: f = r^a and its two derivatives in Q16.32.
// Depends on tsp_pkg for widths, register indexes and the log2/exp2 tables.
//
//   channel | ports                 | direction | moves
//   req     | valid, stall, temp    | in        | one temperature per transfer
//   rsp     | valid, stall, results | out       | one result set per transfer
//   csr     | wr_en, index, wdata   | in        | register write, no read-back
//
// One item enters per cycle while no result is held; the datapath has 13 stages
// (four log2 lanes, a multiply stage, three exp2 lanes, each lookup three deep).
// A held result (rsp_valid with rsp_stall) freezes every stage and raises req_stall.
// Reset clears the valid bits and restores the register defaults.
`default_nettype none

module thermal_softening_power_law_core import tsp_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [20:0]        csr_wdata,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [20:0]        req_temperature,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [47:0] rsp_softening_value,
   output logic signed [47:0] rsp_first_derivative,
   output logic signed [47:0] rsp_second_derivative,
   output logic               rsp_saturated
);

   localparam int NS  = 13;
   localparam int LN  = 4;   // log lanes: span, span-d, a, |a-1|
   localparam int XN  = 3;   // exp lanes: f, df, d2f
   localparam int NW  = 22;
   localparam int EW  = 5;
   localparam int LGW = 40;
   localparam int MW  = 58;
   localparam int XW  = 48;
   localparam logic signed [XW-1:0] ONE_X = 48'sh1_0000_0000;
   localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000;

   logic [20:0] ref_temp_ff;
   logic [20:0] span_ff;
   logic [15:0] expo_ff;

   logic          adv;
   logic [NS-1:0] vld_ff;
   side_type      side_ff [NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_temp_ff <= 21'd76800;
         span_ff     <= 21'd256000;
         expo_ff     <= 16'd4096;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_TEMP: ref_temp_ff <= csr_wdata;
            CSR_SPAN:     span_ff     <= csr_wdata;
            CSR_EXPONENT: expo_ff     <= csr_wdata[15:0];
            default:      ;
         endcase
      end
   end

   assign adv       = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   // ---- stage 1: offset from reference, lane operands
   logic signed [22:0] dlt;
   logic signed [22:0] nx;
   logic signed [16:0] am1;
   logic [15:0]        am1_mag;
   side_type           side_in;
   logic [NW-1:0]      n1_in [LN];
   logic [NW-1:0]      n1_ff [LN];

   always_comb begin
      dlt          = $signed({2'b00, req_temperature}) - $signed({2'b00, ref_temp_ff});
      nx           = $signed({2'b00, span_ff}) - dlt;
      am1          = $signed({1'b0, expo_ff}) - 17'sd4096;
      am1_mag      = am1[16] ? 16'(-am1) : am1[15:0];
      side_in.live = (span_ff != '0) && (dlt < $signed({2'b00, span_ff}));
      side_in.expo = expo_ff;
      side_in.am1  = am1;
      n1_in[0]     = {1'b0, span_ff};
      n1_in[1]     = nx[NW-1:0];
      n1_in[2]     = {6'd0, expo_ff};
      n1_in[3]     = {6'd0, am1_mag};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < NS - 1; s++) side_ff[s] <= side_ff[s-1];
         for (int l = 0; l < LN; l++) n1_ff[l] <= n1_in[l];
      end
   end

   // ---- stage 2: leading one and fraction below it
   logic [EW-1:0]    e2_in  [LN];
   logic [EW-1:0]    e2_ff  [LN];
   logic [31+NW:0]   sh2    [LN];
   logic [31:0]      fr2_in [LN];
   logic [31:0]      fr2_ff [LN];

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         e2_in[l] = '0;
         for (int b = 0; b < NW; b++) begin
            if (n1_ff[l][b]) e2_in[l] = EW'(b);
         end
         sh2[l]    = {32'd0, n1_ff[l]} << (6'd32 - {1'b0, e2_in[l]});
         fr2_in[l] = sh2[l][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            e2_ff[l]  <= e2_in[l];
            fr2_ff[l] <= fr2_in[l];
         end
      end
   end

   // ---- stage 3: table position
   logic [PW-1:0] p3    [LN];
   logic [KW-1:0] k3_ff [LN];
   logic [31:0]   t3_ff [LN];
   logic [EW-1:0] e3_ff [LN];

   always_comb begin
      for (int l = 0; l < LN; l++) p3[l] = PW'(fr2_ff[l]) * PW'(TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            k3_ff[l] <= p3[l][PW-1:32];
            t3_ff[l] <= p3[l][31:0];
            e3_ff[l] <= e2_ff[l];
         end
      end
   end

   // ---- stage 4: log table read
   logic [TAB_W-1:0] lo4_in [LN];
   logic [TAB_W-1:0] hi4_in [LN];
   logic [TAB_W-1:0] lo4_ff [LN];
   logic [TAB_W-1:0] dm4_ff [LN];
   logic             dn4_ff [LN];
   logic [31:0]      t4_ff  [LN];
   logic [EW-1:0]    e4_ff  [LN];

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         lo4_in[l] = LOG_TAB[k3_ff[l]];
         hi4_in[l] = LOG_TAB[KW'(k3_ff[l] + 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            lo4_ff[l] <= lo4_in[l];
            dn4_ff[l] <= hi4_in[l] < lo4_in[l];
            dm4_ff[l] <= (hi4_in[l] < lo4_in[l]) ? lo4_in[l] - hi4_in[l]
                                                  : hi4_in[l] - lo4_in[l];
            t4_ff[l]  <= t3_ff[l];
            e4_ff[l]  <= e3_ff[l];
         end
      end
   end

   // ---- stage 5: interpolation product
   logic [TAB_W+31:0] pr5    [LN];
   logic [TAB_W-1:0]  pr5_ff [LN];
   logic [TAB_W-1:0]  lo5_ff [LN];
   logic              dn5_ff [LN];
   logic [EW-1:0]     e5_ff  [LN];

   always_comb begin
      for (int l = 0; l < LN; l++) pr5[l] = (TAB_W+32)'(dm4_ff[l]) * (TAB_W+32)'(t4_ff[l]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            pr5_ff[l] <= pr5[l][TAB_W+31:32];
            lo5_ff[l] <= lo4_ff[l];
            dn5_ff[l] <= dn4_ff[l];
            e5_ff[l]  <= e4_ff[l];
         end
      end
   end

   // ---- stage 6: assemble log2 values
   logic signed [LGW-1:0] lg6_in [LN];
   logic signed [LGW-1:0] lg6_ff [LN];

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         lg6_in[l] = $signed({3'd0, e5_ff[l], 32'd0})
                   + (dn5_ff[l] ? $signed(LGW'(lo5_ff[l] - pr5_ff[l]))
                                : $signed(LGW'(lo5_ff[l] + pr5_ff[l])));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LN; l++) lg6_ff[l] <= lg6_in[l];
      end
   end

   // ---- stage 7: log2 of r
   logic signed [LGW-1:0] lgd7_ff;
   logic signed [LGW-1:0] lga7_ff;
   logic signed [LGW-1:0] lgs7_ff;
   logic signed [LGW-1:0] lgm7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lgd7_ff <= lg6_ff[1] - lg6_ff[0];
         lgs7_ff <= lg6_ff[0];
         lga7_ff <= lg6_ff[2];
         lgm7_ff <= lg6_ff[3];
      end
   end

   // ---- stage 8: exponent products
   logic signed [17:0]   fac8   [XN];
   logic signed [MW-1:0] m8_in  [XN];
   logic signed [MW-1:0] m8_ff  [XN];
   logic signed [LGW-1:0] lga8_ff;
   logic signed [LGW-1:0] lgs8_ff;
   logic signed [LGW-1:0] lgm8_ff;

   always_comb begin
      fac8[0] = $signed({2'b00, side_ff[6].expo});
      fac8[1] = $signed({side_ff[6].am1[16], side_ff[6].am1});
      fac8[2] = $signed({2'b00, side_ff[6].expo}) - 18'sd8192;
      for (int x = 0; x < XN; x++) m8_in[x] = lgd7_ff * fac8[x];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int x = 0; x < XN; x++) m8_ff[x] <= m8_in[x];
         lga8_ff <= lga7_ff;
         lgs8_ff <= lgs7_ff;
         lgm8_ff <= lgm7_ff;
      end
   end

   // ---- stage 9: base-2 exponents (floor division by 4096 is the arithmetic shift)
   logic signed [XW-1:0] q9   [XN];
   logic signed [XW-1:0] lga9;
   logic signed [XW-1:0] lgs9;
   logic signed [XW-1:0] lgm9;
   logic signed [XW-1:0] x9_in [XN];
   logic signed [XW-1:0] x9_ff [XN];

   always_comb begin
      for (int x = 0; x < XN; x++) q9[x] = {{2{m8_ff[x][MW-1]}}, m8_ff[x][MW-1:12]};
      lga9     = {{(XW-LGW){lga8_ff[LGW-1]}}, lga8_ff};
      lgs9     = {{(XW-LGW){lgs8_ff[LGW-1]}}, lgs8_ff};
      lgm9     = {{(XW-LGW){lgm8_ff[LGW-1]}}, lgm8_ff};
      x9_in[0] = q9[0];
      x9_in[1] = q9[1] + lga9 - lgs9 - (ONE_X <<< 2);
      x9_in[2] = q9[2] + lga9 + lgm9 - (lgs9 <<< 1) - (ONE_X <<< 3);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int x = 0; x < XN; x++) x9_ff[x] <= x9_in[x];
      end
   end

   // ---- stage 10: split into integer part and table position
   logic [PW-1:0]      p10     [XN];
   logic [KW-1:0]      k10_ff  [XN];
   logic [31:0]        t10_ff  [XN];
   logic signed [15:0] ip10_ff [XN];

   always_comb begin
      for (int x = 0; x < XN; x++) p10[x] = PW'(x9_ff[x][31:0]) * PW'(TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int x = 0; x < XN; x++) begin
            k10_ff[x]  <= p10[x][PW-1:32];
            t10_ff[x]  <= p10[x][31:0];
            ip10_ff[x] <= x9_ff[x][XW-1:32];
         end
      end
   end

   // ---- stage 11: exp table read
   logic [TAB_W-1:0]   lo11_in [XN];
   logic [TAB_W-1:0]   hi11_in [XN];
   logic [TAB_W-1:0]   lo11_ff [XN];
   logic [TAB_W-1:0]   dm11_ff [XN];
   logic               dn11_ff [XN];
   logic [31:0]        t11_ff  [XN];
   logic signed [15:0] ip11_ff [XN];

   always_comb begin
      for (int x = 0; x < XN; x++) begin
         lo11_in[x] = EXP_TAB[k10_ff[x]];
         hi11_in[x] = EXP_TAB[KW'(k10_ff[x] + 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int x = 0; x < XN; x++) begin
            lo11_ff[x] <= lo11_in[x];
            dn11_ff[x] <= hi11_in[x] < lo11_in[x];
            dm11_ff[x] <= (hi11_in[x] < lo11_in[x]) ? lo11_in[x] - hi11_in[x]
                                                    : hi11_in[x] - lo11_in[x];
            t11_ff[x]  <= t10_ff[x];
            ip11_ff[x] <= ip10_ff[x];
         end
      end
   end

   // ---- stage 12: interpolation product
   logic [TAB_W+31:0]  pr12    [XN];
   logic [TAB_W-1:0]   pr12_ff [XN];
   logic [TAB_W-1:0]   lo12_ff [XN];
   logic               dn12_ff [XN];
   logic signed [15:0] ip12_ff [XN];

   always_comb begin
      for (int x = 0; x < XN; x++) begin
         pr12[x] = (TAB_W+32)'(dm11_ff[x]) * (TAB_W+32)'(t11_ff[x]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int x = 0; x < XN; x++) begin
            pr12_ff[x] <= pr12[x][TAB_W+31:32];
            lo12_ff[x] <= lo11_ff[x];
            dn12_ff[x] <= dn11_ff[x];
            ip12_ff[x] <= ip11_ff[x];
         end
      end
   end

   // ---- stage 13: scale by 2^I, clip, sign, gate special cases
   side_type           sd13;
   logic [TAB_W-1:0]   m13   [XN];
   logic [63:0]        mag13 [XN];
   logic [63:0]        lim13 [XN];
   logic [15:0]        nip13 [XN];
   logic               neg13 [XN];
   logic               clp13 [XN];
   logic               en13  [XN];
   logic [47:0]        res13 [XN];
   logic               sat13;
   logic signed [47:0] val_ff;
   logic signed [47:0] dv1_ff;
   logic signed [47:0] dv2_ff;
   logic               sat_ff;

   always_comb begin
      sd13     = side_ff[NS-2];
      neg13[0] = 1'b0;
      neg13[1] = 1'b1;
      neg13[2] = sd13.am1[16];
      en13[0]  = sd13.live;
      en13[1]  = sd13.live && (sd13.expo != '0);
      en13[2]  = en13[1] && (sd13.am1 != '0);
      sat13    = 1'b0;
      for (int x = 0; x < XN; x++) begin
         m13[x]   = dn12_ff[x] ? lo12_ff[x] - pr12_ff[x] : lo12_ff[x] + pr12_ff[x];
         lim13[x] = neg13[x] ? SAT_NEG : SAT_POS;
         nip13[x] = 16'(-ip12_ff[x]);
         if (ip12_ff[x] >= 16'sd15) begin
            mag13[x] = lim13[x] + 64'd1;
         end else if (!ip12_ff[x][15]) begin
            mag13[x] = {30'd0, m13[x]} << ip12_ff[x][3:0];
         end else if (nip13[x] >= 16'd64) begin
            mag13[x] = '0;
         end else begin
            mag13[x] = {30'd0, m13[x]} >> nip13[x][5:0];
         end
         clp13[x] = mag13[x] > lim13[x];
         if (clp13[x]) mag13[x] = lim13[x];
         res13[x] = neg13[x] ? 48'(-mag13[x][47:0]) : mag13[x][47:0];
         if (!en13[x]) res13[x] = '0;
         sat13 = sat13 | (en13[x] & clp13[x]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff <= $signed(res13[0]);
         dv1_ff <= $signed(res13[1]);
         dv2_ff <= $signed(res13[2]);
         sat_ff <= sat13;
      end
   end

   assign rsp_softening_value   = val_ff;
   assign rsp_first_derivative  = dv1_ff;
   assign rsp_second_derivative = dv2_ff;
   assign rsp_saturated         = sat_ff;

endmodule

`default_nettype wire

// ===== src/tsp_checker.sv =====
// Port-level checker for the softening core, bound to its top level.
// Depends on the assertion macros in thermal_softening_power_law_core_assert.svh.
`default_nettype none
`include "thermal_softening_power_law_core_assert.svh"

module tsp_port_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [47:0] rsp_softening_value,
   input wire [47:0] rsp_first_derivative,
   input wire [47:0] rsp_second_derivative,
   input wire        rsp_saturated
);

   // held result keeps its softening value and saturated flag
   `TSP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_softening_value) && $stable(rsp_saturated))

   // input side only backs up behind a held result
   `TSP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // factor is never negative, first derivative never positive
   `TSP_ASSERT_NOW(a_signs, clock, reset, rsp_valid, !rsp_softening_value[47] && (rsp_first_derivative[47] || rsp_first_derivative == 48'd0))

   // a clip leaves at least one result at a range limit
   `TSP_ASSERT_NOW(a_sat_limit, clock, reset, rsp_valid && rsp_saturated, rsp_softening_value == 48'h7FFF_FFFF_FFFF || rsp_first_derivative == 48'h8000_0000_0000 || rsp_second_derivative == 48'h7FFF_FFFF_FFFF || rsp_second_derivative == 48'h8000_0000_0000)

endmodule

bind thermal_softening_power_law_core tsp_port_checker u_tsp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_softening_value   (rsp_softening_value),
   .rsp_first_derivative  (rsp_first_derivative),
   .rsp_second_derivative (rsp_second_derivative),
   .rsp_saturated         (rsp_saturated)
);

`default_nettype wire
